// ----- hw/rtl/ia32_pkg.sv -----
package ia32_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CountWidth = 6;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_NEG = 3'd0,
    CMD_ADD = 3'd1,
    CMD_SUB = 3'd2,
    CMD_MUL = 3'd3,
    CMD_DIV = 3'd4,
    CMD_POW = 3'd5,
    CMD_MOD = 3'd6,
    CMD_REM = 3'd7
  } cmd_t;

  // Work class decided by the front end.
  typedef enum logic [1:0] {
    CLS_DONE = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_POW  = 2'd2,
    CLS_DIV  = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t cls;
    cmd_t cmd;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic dz;
  } task_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POW,
    ST_DIV,
    ST_FIX,
    ST_OUT
  } state_t;

endpackage

// ----- hw/rtl/ia32_front.sv -----
module ia32_front (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [2:0] command,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic q_valid,
  input  logic q_ready,
  output ia32_pkg::task_t q_word
);

  ia32_pkg::task_t word;
  ia32_pkg::task_t mem [ia32_pkg::QueueDepth];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic pop;

  // Simple operations are finished here; the rest carry their operands on.
  always_comb begin
    word.cmd = ia32_pkg::cmd_t'(command);
    word.a = operand_a;
    word.b = operand_b;
    word.dz = 1'b0;
    word.cls = ia32_pkg::CLS_DONE;
    unique case (ia32_pkg::cmd_t'(command))
      ia32_pkg::CMD_NEG: word.a = 32'd0 - operand_a;
      ia32_pkg::CMD_ADD: word.a = operand_a + operand_b;
      ia32_pkg::CMD_SUB: word.a = operand_a - operand_b;
      ia32_pkg::CMD_MUL: word.cls = ia32_pkg::CLS_MUL;
      ia32_pkg::CMD_POW: begin
        if (operand_b[31]) begin
          if (operand_a == 32'd1) word.a = 32'd1;
          else if (operand_a == 32'hFFFF_FFFF)
            word.a = operand_b[0] ? 32'hFFFF_FFFF : 32'd1;
          else word.a = 32'd0;
        end else begin
          word.cls = ia32_pkg::CLS_POW;
        end
      end
      ia32_pkg::CMD_DIV: begin
        if (operand_b == 32'd0) begin
          word.dz = 1'b1;
          word.a = 32'd0;
        end else begin
          word.cls = ia32_pkg::CLS_DIV;
        end
      end
      ia32_pkg::CMD_MOD, ia32_pkg::CMD_REM: begin
        if (operand_a == 32'd0) begin
          word.dz = 1'b1;
          word.a = 32'd0;
        end else begin
          word.cls = ia32_pkg::CLS_DIV;
        end
      end
      default: word.cls = ia32_pkg::CLS_DONE;
    endcase
  end

  assign ready = (count != 2'd2);
  assign push = valid && ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/ia32_back.sv -----
module ia32_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  ia32_pkg::task_t q_word,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] out_result,
  output logic out_dz
);

  ia32_pkg::state_t state;
  ia32_pkg::state_t state_next;
  ia32_pkg::cmd_t cmd;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] acc;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [ia32_pkg::CountWidth-1:0] cnt;
  logic dz;
  logic neg_q;
  logic neg_r;
  logic [32:0] trial;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [31:0] prod;
  logic [31:0] rfix;

  assign mag_a = q_word.a[31] ? 32'd0 - q_word.a : q_word.a;
  assign mag_b = q_word.b[31] ? 32'd0 - q_word.b : q_word.b;
  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_comb begin
    state_next = state;
    unique case (state)
      ia32_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_word.cls)
            ia32_pkg::CLS_MUL: state_next = ia32_pkg::ST_MUL;
            ia32_pkg::CLS_POW: state_next = ia32_pkg::ST_POW;
            ia32_pkg::CLS_DIV: state_next = ia32_pkg::ST_DIV;
            default: state_next = ia32_pkg::ST_OUT;
          endcase
        end
      end
      ia32_pkg::ST_MUL: state_next = ia32_pkg::ST_OUT;
      ia32_pkg::ST_POW: if (cnt[0] && b == 32'd0) state_next = ia32_pkg::ST_OUT;
      ia32_pkg::ST_DIV: if (cnt == 6'd31) state_next = ia32_pkg::ST_FIX;
      ia32_pkg::ST_FIX: state_next = ia32_pkg::ST_OUT;
      ia32_pkg::ST_OUT: if (out_ready) state_next = ia32_pkg::ST_IDLE;
      default: state_next = ia32_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ia32_pkg::ST_IDLE);
    out_valid = (state == ia32_pkg::ST_OUT);
  end

  // One shared multiplier; power alternates the accumulate and square steps.
  assign mul_x = (state == ia32_pkg::ST_POW && !cnt[0]) ? acc : a;
  assign mul_y = (state == ia32_pkg::ST_MUL) ? b : a;
  assign prod = mul_x * mul_y;

  always_comb begin
    rfix = neg_r ? 32'd0 - rem : rem;
    if (cmd == ia32_pkg::CMD_MOD && rfix != 32'd0 && (rfix[31] ^ a[31]))
      rfix = rfix + a;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ia32_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ia32_pkg::ST_IDLE: begin
        cmd <= q_word.cmd;
        a <= q_word.a;
        b <= q_word.b;
        dz <= q_word.dz;
        acc <= 32'd1;
        cnt <= 6'd0;
        rem <= 32'd0;
        out_result <= q_word.a;
        out_dz <= q_word.dz;
        if (q_word.cmd == ia32_pkg::CMD_DIV) begin
          quo <= mag_a;
          dvs <= mag_b;
          neg_q <= q_word.a[31] ^ q_word.b[31];
          neg_r <= 1'b0;
        end else begin
          quo <= mag_b;
          dvs <= mag_a;
          neg_q <= 1'b0;
          neg_r <= q_word.b[31];
        end
      end
      ia32_pkg::ST_MUL: out_result <= prod;
      ia32_pkg::ST_POW: begin
        cnt <= {5'd0, ~cnt[0]};
        if (!cnt[0]) begin
          if (b[0]) acc <= prod;
          if (b[31:1] == 31'd0) out_result <= b[0] ? prod : acc;
        end else begin
          a <= prod;
          b <= {1'b0, b[31:1]};
          if (b == 32'd0) out_result <= acc;
        end
      end
      ia32_pkg::ST_DIV: begin
        cnt <= cnt + 6'd1;
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
      end
      ia32_pkg::ST_FIX: begin
        out_dz <= dz;
        if (cmd == ia32_pkg::CMD_DIV) out_result <= neg_q ? 32'd0 - quo : quo;
        else out_result <= rfix;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/int32_arith_unit_pow_mod.sv -----
// 32-bit signed arithmetic unit: negate, add, subtract, multiply, divide, power,
// floored modulo and truncated remainder, each word giving one wrapped result.
// A front end resolves simple commands and zero divisors and queues two words;
// the back end then runs divide, modulo and remainder one radix-2 step a cycle,
// and power on the shared multiplier.
module int32_arith_unit_pow_mod (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] command,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] result,
  output logic divide_by_zero
);

  logic q_valid;
  logic q_ready;
  ia32_pkg::task_t q_word;
  logic [31:0] res;

  ia32_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .command(command), .operand_a(operand_a), .operand_b(operand_b),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  ia32_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_result(res),
    .out_dz(divide_by_zero)
  );

  assign result = res;

endmodule

// ----- tb/tb_int32_arith_unit_pow_mod.sv -----
`timescale 1ns / 1ps

module tb_int32_arith_unit_pow_mod;

  localparam int RandomWords = 700;
  localparam int LongStall = 300;

  typedef struct {
    ia32_pkg::cmd_t cmd;
    logic [31:0] a;
    logic [31:0] b;
    bit known;
    logic [31:0] res;
    logic dz;
  } vec_t;

  typedef struct {
    logic [31:0] res;
    logic dz;
  } alu_out_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [2:0] command;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] result;
  logic divide_by_zero;

  alu_out_t expected_q[$];
  int errors;
  int words_sent;
  int words_checked;
  bit stall_sink;
  bit quiet_phase;

  int32_arith_unit_pow_mod u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .result(result),
    .divide_by_zero(divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] magnitude(logic [31:0] x);
    return x[31] ? 32'(0 - x) : x;
  endfunction

  // Remainder of x by m with the sign of x.
  function automatic logic [31:0] trunc_mod(logic [31:0] x, logic [31:0] m);
    logic [31:0] r;
    r = magnitude(x) % magnitude(m);
    return x[31] ? 32'(0 - r) : r;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    acc = 32'd1;
    if (ex[31]) begin
      if (base == 32'd1) return 32'd1;
      if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
      return 32'd0;
    end
    while (ex != 0) begin
      if (ex[0]) acc = acc * base;
      ex = ex >> 1;
      base = base * base;
    end
    return acc;
  endfunction

  function automatic alu_out_t compute_alu(ia32_pkg::cmd_t cmd, logic [31:0] a,
                                           logic [31:0] b);
    alu_out_t o;
    logic [31:0] q;
    o.res = '0;
    o.dz = 1'b0;
    case (cmd)
      ia32_pkg::CMD_NEG: o.res = 32'(0 - a);
      ia32_pkg::CMD_ADD: o.res = a + b;
      ia32_pkg::CMD_SUB: o.res = a - b;
      ia32_pkg::CMD_MUL: o.res = a * b;
      ia32_pkg::CMD_DIV: begin
        if (b == 0) o.dz = 1'b1;
        else begin
          q = magnitude(a) / magnitude(b);
          o.res = (a[31] ^ b[31]) ? 32'(0 - q) : q;
        end
      end
      ia32_pkg::CMD_POW: o.res = int_power(a, b);
      ia32_pkg::CMD_MOD: begin
        if (a == 0) o.dz = 1'b1;
        else begin
          o.res = trunc_mod(b, a);
          if (o.res != 0 && (o.res[31] ^ a[31])) o.res = o.res + a;
        end
      end
      default: begin
        if (a == 0) o.dz = 1'b1;
        else o.res = trunc_mod(b, a);
      end
    endcase
    return o;
  endfunction

  vec_t directed[$];

  function automatic void add_row(ia32_pkg::cmd_t c, logic [31:0] a, logic [31:0] b,
                                  bit k = 1'b0, logic [31:0] r = '0, logic d = 1'b0);
    vec_t v;
    v.cmd = c; v.a = a; v.b = b; v.known = k; v.res = r; v.dz = d;
    directed.push_back(v);
  endfunction

  task automatic send_word(ia32_pkg::cmd_t c, logic [31:0] a, logic [31:0] b, bit k,
                           alu_out_t e);
    alu_out_t p;
    if (!quiet_phase) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    p = compute_alu(c, a, b);
    if (k && (p.res !== e.res || p.dz !== e.dz))
      $display("%0t: table row cmd %0d disagrees with predictor", $time, c);
    in_valid <= 1'b1;
    command <= c;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(k ? e : p);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Results are sampled at the edge where the word is taken.
  always @(posedge clk) begin
    alu_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: result %h dz %b",
                 $time, result, divide_by_zero);
        errors++;
      end else begin
        e = expected_q.pop_front();
        words_checked++;
        if (result !== e.res) begin
          $display("%0t: result expected %h actual %h", $time, e.res, result);
          errors++;
        end
        if (divide_by_zero !== e.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b",
                   $time, e.dz, divide_by_zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (stall_sink) out_ready <= 1'b0;
    else if (quiet_phase) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 8);
  end

  // Sink holds off for a long stretch so the queue fills and in_ready drops.
  initial begin
    stall_sink = 1'b0;
    wait (words_sent == 60);
    @(posedge clk);
    stall_sink = 1'b1;
    repeat (LongStall) @(posedge clk);
    stall_sink = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    vec_t v;
    alu_out_t e;
    ia32_pkg::cmd_t c;
    logic [31:0] a;
    logic [31:0] b;
    int sel;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    quiet_phase = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = '0;
    operand_a = '0;
    operand_b = '0;

    add_row(ia32_pkg::CMD_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0);
    add_row(ia32_pkg::CMD_NEG, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h8000_0001, 1'b0);
    add_row(ia32_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h1, 1'b1, 32'h8000_0000, 1'b0);
    add_row(ia32_pkg::CMD_SUB, 32'h8000_0000, 32'h1, 1'b1, 32'h7FFF_FFFF, 1'b0);
    add_row(ia32_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h1, 1'b0);
    add_row(ia32_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'h8000_0000);
    add_row(ia32_pkg::CMD_DIV, 32'h1234, 32'h0, 1'b1, 32'h0, 1'b1);
    add_row(ia32_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0);
    add_row(ia32_pkg::CMD_DIV, 32'hFFFF_FFF9, 32'h2, 1'b1, 32'hFFFF_FFFD, 1'b0);
    add_row(ia32_pkg::CMD_POW, 32'h3, 32'h13);
    add_row(ia32_pkg::CMD_POW, 32'h1, 32'h8000_0000, 1'b1, 32'h1, 1'b0);
    add_row(ia32_pkg::CMD_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_row(ia32_pkg::CMD_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h1, 1'b0);
    add_row(ia32_pkg::CMD_POW, 32'h2, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0);
    add_row(ia32_pkg::CMD_POW, 32'h7, 32'h7FFF_FFFF);
    add_row(ia32_pkg::CMD_POW, 32'h0, 32'h0, 1'b1, 32'h1, 1'b0);
    add_row(ia32_pkg::CMD_MOD, 32'h0, 32'h5, 1'b1, 32'h0, 1'b1);
    add_row(ia32_pkg::CMD_MOD, 32'h3, 32'hFFFF_FFF9, 1'b1, 32'h2, 1'b0);
    add_row(ia32_pkg::CMD_MOD, 32'hFFFF_FFFD, 32'h7, 1'b1, 32'hFFFF_FFFE, 1'b0);
    add_row(ia32_pkg::CMD_MOD, 32'h8000_0000, 32'h7FFF_FFFF);
    add_row(ia32_pkg::CMD_REM, 32'h0, 32'h9, 1'b1, 32'h0, 1'b1);
    add_row(ia32_pkg::CMD_REM, 32'h3, 32'hFFFF_FFF9, 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_row(ia32_pkg::CMD_REM, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0, 1'b0);
    add_row(ia32_pkg::CMD_REM, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      v = directed[i];
      e.res = v.res;
      e.dz = v.dz;
      send_word(v.cmd, v.a, v.b, v.known, e);
    end

    for (int n = 0; n < RandomWords; n++) begin
      // A stretch of back-to-back traffic in the middle of the run.
      quiet_phase = (n >= 300 && n < 420);
      if (n == 200) drain_results();
      c = ia32_pkg::cmd_t'($urandom_range(7));
      sel = $urandom_range(9);
      a = $urandom();
      b = $urandom();
      if (sel < 3) a = 32'($signed($urandom_range(40)) - 20);
      if (sel == 3 || sel == 4) b = 32'($signed($urandom_range(40)) - 20);
      if (sel == 5) b = $urandom_range(16);
      if (sel == 6) a = {1'($urandom_range(1)), 31'h0};
      send_word(c, a, b, 1'b0, e);
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("Covered %0d words over all eight commands, %0d results checked,",
             words_sent, words_checked);
    $display("with random idles, a long output stall and a full drain mid-run.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
